/* rtl/sps_pkg.sv */
// Shared constants, codes and widths for the segmented prime sieve core.
// No dependencies; compile first.
package sps_pkg;

  localparam int TABLE_DEPTH  = 131072;
  localparam int SEGMENT_SPAN = 1048576;
  localparam int WORD_BITS    = 64;
  localparam int WORD_SHIFT   = 6;
  localparam int BITMAP_WORDS = (SEGMENT_SPAN + WORD_BITS - 1) / WORD_BITS;
  localparam int TBL_AW       = $clog2(TABLE_DEPTH);
  localparam int CNT_W        = TBL_AW + 1;
  localparam int BM_AW        = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int OFF_W        = WORD_SHIFT + BM_AW;
  localparam int VAL_W        = 64;
  localparam int PRIME_W      = 32;
  localparam int COUNT_W      = 20;
  localparam int DIV_CW       = $clog2(VAL_W);

  typedef logic [1:0] action_t;
  localparam action_t ACT_LOAD    = 2'd0;
  localparam action_t ACT_SEGMENT = 2'd1;
  localparam action_t ACT_TEST    = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_SHORT = 2'd1;
  localparam status_t ST_SPAN  = 2'd2;

endpackage

/* rtl/sps_if.sv */
// Valid/ready channel interfaces for requests and responses of the sieve core.
// Depends on sps_pkg.
interface sps_req_if;
  logic                      valid;
  logic                      ready;
  sps_pkg::action_t          action;
  logic [sps_pkg::VAL_W-1:0] lower;
  logic [sps_pkg::VAL_W-1:0] upper;

  modport source (output valid, action, lower, upper, input ready);
  modport sink   (input valid, action, lower, upper, output ready);
endinterface

interface sps_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [sps_pkg::COUNT_W-1:0] prime_count;
  logic [sps_pkg::VAL_W-1:0]   max_prime;
  logic                        prime_flag;
  sps_pkg::status_t            status;

  modport source (output valid, prime_count, max_prime, prime_flag, status, input ready);
  modport sink   (input valid, prime_count, max_prime, prime_flag, status, output ready);
endinterface

/* rtl/segmented_prime_sieve_core.sv */
// Segmented prime sieve core: base-prime table, segment bitmap, sieve and test engine.
// Depends on sps_pkg and the channel interfaces in sps_if.
//
// One request is worked at a time. A table load is written in the cycle it is
// accepted. A primality test walks the base entries, each through fetch, square,
// compare and the 64-step remainder unit. A segment clears the bitmap words that it
// covers, walks each odd base prime through the remainder unit for its first
// multiple, marks each multiple by a read-modify-write of its bitmap word, and
// counts with a scan that tests one odd number per cycle, with a read per word.
// The response is held in an output register until taken.
module segmented_prime_sieve_core (
  input  logic           clk,
  input  logic           rst,
  sps_req_if.sink        req,
  sps_rsp_if.source      rsp
);
  import sps_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_COV, S_DECIDE, S_CLEAR, S_FETCH, S_SQ, S_TEST, S_DIV, S_K, S_J,
    S_MARK_CHK, S_MARK_RD, S_MARK_WR, S_SCAN_RD, S_SCAN_BIT, S_FINISH
  } state_t;

  state_t state;

  logic [PRIME_W-1:0]   bp_mem [TABLE_DEPTH];
  logic [PRIME_W-1:0]   bp_rdata;
  logic [WORD_BITS-1:0] bm_mem [BITMAP_WORDS];
  logic [WORD_BITS-1:0] bm_rdata;

  logic [CNT_W-1:0]   base_count;
  logic [PRIME_W-1:0] last_entry;
  logic [VAL_W-1:0]   lps;
  logic [VAL_W-1:0]   lo_r;
  logic [VAL_W-1:0]   hi_r;
  logic               is_seg;
  logic [COUNT_W-1:0] cnt;
  logic               prime_bit;
  status_t            stat;
  logic               cov_big;
  logic [PRIME_W-1:0] cov_c1;
  logic [VAL_W-1:0]   cov_sq;
  logic [BM_AW-1:0]   clr;
  logic [BM_AW-1:0]   clr_last;
  logic [CNT_W-1:0]   t;
  logic [PRIME_W-1:0] p;
  logic [VAL_W-1:0]   sq;
  logic [VAL_W-1:0]   dv;
  logic [PRIME_W-1:0] rem;
  logic [DIV_CW-1:0]  div_cnt;
  logic [VAL_W-1:0]   k;
  logic [VAL_W-1:0]   j;
  logic [PRIME_W:0]   step;
  logic [BM_AW-1:0]   mk_addr;
  logic [WORD_SHIFT-1:0] mk_bit;
  logic [VAL_W-1:0]   x;
  logic [VAL_W-1:0]   found;
  logic [OFF_W-1:0]   off;
  logic               any;

  logic               o_valid;
  logic [COUNT_W-1:0] o_count;
  logic [VAL_W-1:0]   o_last;
  logic               o_prime;
  status_t            o_status;

  logic               req_fire;
  logic [VAL_W-1:0]   lo_adj;
  logic               lo_small;
  logic [PRIME_W-1:0] cov_c;
  logic [PRIME_W-1:0] cov_floor;
  logic [VAL_W-1:0]   diff;
  logic [VAL_W-1:0]   sq_prod;
  logic [VAL_W-1:0]   mk_off;
  logic [PRIME_W:0]   div_t;
  logic [PRIME_W:0]   div_r;
  logic [VAL_W:0]     k_sum;
  logic [VAL_W:0]     kp_sum;
  logic [VAL_W-1:0]   k_odd;
  logic               unmarked;
  logic [VAL_W-1:0]   found_n;
  logic               any_n;
  logic               bm_we;
  logic [BM_AW-1:0]   bm_waddr;
  logic [WORD_BITS-1:0] bm_wdata;
  logic               bm_re;
  logic [BM_AW-1:0]   bm_raddr;
  logic               bp_we;
  logic               bp_re;

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;

  assign rsp.valid       = o_valid;
  assign rsp.prime_count = o_count;
  assign rsp.max_prime   = o_last;
  assign rsp.prime_flag  = o_prime;
  assign rsp.status      = o_status;

  always_comb begin
    lo_small  = (req.lower < VAL_W'(3));
    lo_adj    = lo_small ? VAL_W'(3) : (req.lower | VAL_W'(1));
    cov_c     = (base_count != '0) ? last_entry : PRIME_W'(1);
    cov_floor = (req.action == ACT_SEGMENT) ? PRIME_W'(2) : PRIME_W'(1);
    if (cov_c < cov_floor) begin
      cov_c = cov_floor;
    end
    diff     = hi_r - lo_r;
    sq_prod  = VAL_W'(bp_rdata) * VAL_W'(bp_rdata);
    mk_off   = j - lo_r;
    div_t    = {rem, dv[VAL_W-1]};
    div_r    = (div_t >= {1'b0, p}) ? (div_t - {1'b0, p}) : div_t;
    k_sum    = {1'b0, lo_r} + {{(VAL_W-PRIME_W+1){1'b0}}, p - rem};
    kp_sum   = {1'b0, k} + {{(VAL_W-PRIME_W+1){1'b0}}, p};
    k_odd    = kp_sum[VAL_W-1:0];
    unmarked = !bm_rdata[off[WORD_SHIFT-1:0]];
    found_n  = unmarked ? x : found;
    any_n    = any || unmarked;
  end

  always_comb begin
    bm_we    = (state == S_CLEAR) || (state == S_MARK_WR);
    bm_waddr = (state == S_CLEAR) ? clr : mk_addr;
    bm_wdata = (state == S_CLEAR) ? '0 : (bm_rdata | (WORD_BITS'(1) << mk_bit));
    bm_re    = (state == S_MARK_RD) || (state == S_SCAN_RD);
    bm_raddr = (state == S_MARK_RD) ? mk_off[OFF_W-1:WORD_SHIFT] : off[OFF_W-1:WORD_SHIFT];
    bp_we    = req_fire && (req.action == ACT_LOAD) && (base_count < CNT_W'(TABLE_DEPTH));
    bp_re    = (state == S_FETCH) && (t != base_count);
  end

  always_ff @(posedge clk) begin
    if (bp_we) begin
      bp_mem[base_count[TBL_AW-1:0]] <= req.lower[PRIME_W-1:0];
    end
    if (bp_re) begin
      bp_rdata <= bp_mem[t[TBL_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bm_mem[bm_waddr] <= bm_wdata;
    end
    if (bm_re) begin
      bm_rdata <= bm_mem[bm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      base_count <= '0;
      lps        <= VAL_W'(2);
      o_valid    <= 1'b0;
    end else begin
      if (o_valid && rsp.ready && (state != S_FINISH)) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            hi_r      <= req.upper;
            cov_big   <= (cov_c == {PRIME_W{1'b1}});
            cov_c1    <= cov_c + PRIME_W'(1);
            is_seg    <= (req.action == ACT_SEGMENT);
            cnt       <= '0;
            prime_bit <= 1'b0;
            stat      <= ST_OK;
            t         <= '0;
            case (req.action)
              ACT_LOAD: begin
                if (bp_we) begin
                  base_count <= base_count + CNT_W'(1);
                  last_entry <= req.lower[PRIME_W-1:0];
                end
              end
              ACT_SEGMENT: begin
                lo_r  <= lo_adj;
                cnt   <= COUNT_W'(lo_small && (req.upper >= VAL_W'(2)));
                state <= S_COV;
              end
              ACT_TEST: begin
                prime_bit <= (req.upper >= VAL_W'(2));
                state     <= S_COV;
              end
              default: begin
              end
            endcase
          end
        end
        S_COV: begin
          cov_sq <= VAL_W'(cov_c1) * VAL_W'(cov_c1);
          state  <= S_DECIDE;
        end
        S_DECIDE: begin
          if (is_seg && (hi_r >= lo_r) && (diff >= VAL_W'(SEGMENT_SPAN))) begin
            cnt   <= '0;
            stat  <= ST_SPAN;
            state <= S_FINISH;
          end else begin
            if (!(cov_big || (cov_sq > hi_r))) begin
              stat <= ST_SHORT;
            end
            if (is_seg) begin
              if (hi_r >= lo_r) begin
                clr      <= '0;
                clr_last <= diff[OFF_W-1:WORD_SHIFT];
                state    <= S_CLEAR;
              end else begin
                state <= S_FINISH;
              end
            end else begin
              state <= prime_bit ? S_FETCH : S_FINISH;
            end
          end
        end
        S_CLEAR: begin
          if (clr == clr_last) begin
            state <= S_FETCH;
          end else begin
            clr <= clr + BM_AW'(1);
          end
        end
        S_FETCH: begin
          if (t == base_count) begin
            if (is_seg) begin
              x     <= lo_r;
              off   <= '0;
              any   <= 1'b0;
              state <= S_SCAN_RD;
            end else begin
              state <= S_FINISH;
            end
          end else begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          p     <= bp_rdata;
          sq    <= sq_prod;
          state <= S_TEST;
        end
        S_TEST: begin
          if (sq > hi_r) begin
            if (is_seg) begin
              x     <= lo_r;
              off   <= '0;
              any   <= 1'b0;
              state <= S_SCAN_RD;
            end else begin
              state <= S_FINISH;
            end
          end else if (is_seg ? ((p < PRIME_W'(3)) || !p[0]) : (p < PRIME_W'(2))) begin
            t     <= t + CNT_W'(1);
            state <= S_FETCH;
          end else begin
            dv      <= is_seg ? lo_r : hi_r;
            rem     <= '0;
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          rem     <= div_r[PRIME_W-1:0];
          dv      <= {dv[VAL_W-2:0], 1'b0};
          div_cnt <= div_cnt + DIV_CW'(1);
          if (div_cnt == {DIV_CW{1'b1}}) begin
            if (is_seg) begin
              state <= S_K;
            end else if (div_r == '0) begin
              prime_bit <= 1'b0;
              state     <= S_FINISH;
            end else begin
              t     <= t + CNT_W'(1);
              state <= S_FETCH;
            end
          end
        end
        S_K: begin
          step <= {p, 1'b0};
          if (rem == '0) begin
            k     <= lo_r;
            state <= S_J;
          end else if (k_sum[VAL_W]) begin
            t     <= t + CNT_W'(1);
            state <= S_FETCH;
          end else begin
            k     <= k_sum[VAL_W-1:0];
            state <= S_J;
          end
        end
        S_J: begin
          if (!k[0]) begin
            if (kp_sum[VAL_W]) begin
              t     <= t + CNT_W'(1);
              state <= S_FETCH;
            end else begin
              j     <= (k_odd > sq) ? k_odd : sq;
              state <= S_MARK_CHK;
            end
          end else begin
            j     <= (k > sq) ? k : sq;
            state <= S_MARK_CHK;
          end
        end
        S_MARK_CHK: begin
          if (j <= hi_r) begin
            state <= S_MARK_RD;
          end else begin
            t     <= t + CNT_W'(1);
            state <= S_FETCH;
          end
        end
        S_MARK_RD: begin
          mk_addr <= mk_off[OFF_W-1:WORD_SHIFT];
          mk_bit  <= mk_off[WORD_SHIFT-1:0];
          state   <= S_MARK_WR;
        end
        S_MARK_WR: begin
          if ((hi_r - j) < {{(VAL_W-PRIME_W-1){1'b0}}, step}) begin
            t     <= t + CNT_W'(1);
            state <= S_FETCH;
          end else begin
            j     <= j + {{(VAL_W-PRIME_W-1){1'b0}}, step};
            state <= S_MARK_RD;
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_BIT;
        end
        S_SCAN_BIT: begin
          cnt   <= cnt + COUNT_W'(unmarked);
          found <= found_n;
          any   <= any_n;
          if ((hi_r - x) < VAL_W'(2)) begin
            if (any_n && (found_n > lps)) begin
              lps <= found_n;
            end
            state <= S_FINISH;
          end else begin
            x   <= x + VAL_W'(2);
            off <= off + OFF_W'(2);
            if ((off[WORD_SHIFT-1:0] + WORD_SHIFT'(2)) == '0) begin
              state <= S_SCAN_RD;
            end
          end
        end
        S_FINISH: begin
          if (!o_valid || rsp.ready) begin
            o_valid  <= 1'b1;
            o_count  <= cnt;
            o_last   <= lps;
            o_prime  <= prime_bit;
            o_status <= stat;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    base_count <= CNT_W'(TABLE_DEPTH))
    else $error("base table count past depth");

  a_mark_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK_RD) |-> ((j <= hi_r) && (j >= lo_r)))
    else $error("marking outside segment");

  a_span_count: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == ST_SPAN)) |-> (rsp.prime_count == '0))
    else $error("span error with nonzero count");

  a_lps_mono: assert property (@(posedge clk) disable iff (rst)
    !rst |=> (lps >= $past(lps)))
    else $error("last prime decreased");

endmodule

/* tb/segmented_prime_sieve_core_test.sv */
// Testbench for segmented_prime_sieve_core: loads, segment counts and primality tests,
// checked against an in-bench predictor. Depends on sps_pkg and the channels in sps_if.
`timescale 1ns / 100ps

module segmented_prime_sieve_core_test;
  import sps_pkg::*;

  localparam action_t ACT_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 4000000;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [COUNT_W-1:0] prime_count;
    logic [VAL_W-1:0]   max_prime;
    logic               prime_flag;
    status_t            status;
  } sieve_result_t;

  logic clk;
  logic rst;
  int   cycles = 0;
  int   errors = 0;
  int   n_seg, n_test, n_load;
  bit   no_idle;
  int   long_hold;

  sps_req_if req_ch ();
  sps_rsp_if rsp_ch ();

  segmented_prime_sieve_core u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  logic [PRIME_W-1:0] base_tbl [TABLE_DEPTH];
  int                 base_len;
  logic [63:0]        largest_prime;
  sieve_result_t      pending_results [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic bit table_covers(logic [63:0] n, logic [63:0] floor_v);
    logic [63:0] c;
    c = base_len ? {32'd0, base_tbl[base_len-1]} : 64'd1;
    if (c < floor_v) c = floor_v;
    if (c >= 64'hFFFF_FFFF) return 1'b1;
    return (c + 1) * (c + 1) > n;
  endfunction

  function automatic sieve_result_t count_segment(logic [63:0] lo, logic [63:0] hi);
    sieve_result_t r;
    logic [63:0] cnt, p, sq, rem, k, j, x, found;
    bit marks [];
    bit any;
    r = '0;
    cnt = 0;
    if (lo < 3) begin
      if (hi >= 2) cnt = 1;
      lo = 3;
    end
    if (!lo[0]) lo++;
    if (hi >= lo && hi - lo >= SEGMENT_SPAN) begin
      r.status = ST_SPAN;
      r.max_prime = largest_prime;
      return r;
    end
    r.status = table_covers(hi, 2) ? ST_OK : ST_SHORT;
    if (hi >= lo) begin
      marks = new[hi - lo + 1];
      for (int t = 0; t < base_len; t++) begin
        p = {32'd0, base_tbl[t]};
        sq = p * p;
        if (sq > hi) break;
        if (p < 3 || !p[0]) continue;
        rem = lo % p;
        if (rem == 0) k = lo;
        else begin
          if (lo > ALL_ONES - (p - rem)) continue;
          k = lo + (p - rem);
        end
        if (!k[0]) begin
          if (k > ALL_ONES - p) continue;
          k += p;
        end
        j = (k > sq) ? k : sq;
        while (j <= hi) begin
          marks[j - lo] = 1'b1;
          if (hi - j < 2 * p) break;
          j += 2 * p;
        end
      end
      x = lo;
      any = 0;
      found = 0;
      forever begin
        if (!marks[x - lo]) begin
          cnt++;
          found = x;
          any = 1;
        end
        if (hi - x < 2) break;
        x += 2;
      end
      if (any && found > largest_prime) largest_prime = found;
    end
    r.prime_count = cnt[COUNT_W-1:0];
    r.max_prime = largest_prime;
    return r;
  endfunction

  function automatic sieve_result_t trial_divide(logic [63:0] n);
    sieve_result_t r;
    logic [63:0] p;
    r = '0;
    r.prime_flag = (n >= 2);
    r.status = table_covers(n, 1) ? ST_OK : ST_SHORT;
    for (int t = 0; t < base_len && r.prime_flag; t++) begin
      p = {32'd0, base_tbl[t]};
      if (p * p > n) break;
      if (p < 2) continue;
      if (n % p == 0) r.prime_flag = 1'b0;
    end
    r.max_prime = largest_prime;
    return r;
  endfunction

  task automatic send_request(action_t act, logic [63:0] lo, logic [63:0] hi);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.lower  <= lo;
    req_ch.upper  <= hi;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    case (act)
      ACT_LOAD: begin
        n_load++;
        if (base_len < TABLE_DEPTH) begin
          base_tbl[base_len] = lo[31:0];
          base_len++;
        end
      end
      ACT_SEGMENT: begin
        n_seg++;
        pending_results.insert(pending_results.size(), count_segment(lo, hi));
      end
      ACT_TEST: begin
        n_test++;
        pending_results.insert(pending_results.size(), trial_divide(hi));
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      int n;
      @(posedge clk);
      if (long_hold > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (long_hold) @(posedge clk);
        long_hold = 0;
      end
      n = no_idle ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected response transfer");
        errors++;
      end else begin
        sieve_result_t e;
        e = pending_results.pop_front();
        if (rsp_ch.prime_count !== e.prime_count) begin
          $error("prime_count: expected %0d, got %0d", e.prime_count, rsp_ch.prime_count);
          errors++;
        end
        if (rsp_ch.max_prime !== e.max_prime) begin
          $error("max_prime: expected %0d, got %0d", e.max_prime, rsp_ch.max_prime);
          errors++;
        end
        if (rsp_ch.prime_flag !== e.prime_flag) begin
          $error("prime_flag: expected %0d, got %0d", e.prime_flag, rsp_ch.prime_flag);
          errors++;
        end
        if (rsp_ch.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, rsp_ch.status);
          errors++;
        end
      end
    end
  end

  task automatic test_empty_table();
    send_request(ACT_TEST, 0, 7);
    send_request(ACT_SEGMENT, 0, 30);
    send_request(ACT_SEGMENT, 0, 1);
    drain();
  endtask

  task automatic test_load_primes();
    bit composite;
    for (int v = 2; v < 128; v++) begin
      composite = 0;
      for (int d = 2; d * d <= v; d++)
        if (v % d == 0) composite = 1;
      if (!composite) send_request(ACT_LOAD, 64'(v), $urandom());
    end
    drain();
  endtask

  task automatic test_directed();
    send_request(ACT_SEGMENT, 0, 2);
    send_request(ACT_SEGMENT, 2, 100);
    send_request(ACT_SEGMENT, 10, 50);
    send_request(ACT_SEGMENT, 50, 10);
    send_request(ACT_SEGMENT, 4, 4);
    send_request(ACT_SEGMENT, 100, 200);
    send_request(ACT_SEGMENT, 1000, 2000);
    send_request(ACT_SEGMENT, 0, ALL_ONES);
    send_request(ACT_SEGMENT, 3, 3 + SEGMENT_SPAN);
    send_request(ACT_SEGMENT, ALL_ONES - 200, ALL_ONES);
    send_request(ACT_SEGMENT, ALL_ONES, ALL_ONES);
    send_request(ACT_SEGMENT, 995000, 996500);
    send_request(ACT_TEST, 0, 0);
    send_request(ACT_TEST, 0, 1);
    send_request(ACT_TEST, 0, 2);
    send_request(ACT_TEST, 0, 997 * 991);
    send_request(ACT_TEST, 0, 996001);
    send_request(ACT_TEST, 0, 1000003);
    send_request(ACT_TEST, ALL_ONES, ALL_ONES);
    send_request(ACT_NONE, ALL_ONES, ALL_ONES);
    send_request(ACT_NONE, 0, 0);
    drain();
  endtask

  task automatic test_random();
    logic [63:0] lo, hi;
    int sel;
    for (int i = 0; i < 40; i++) begin
      no_idle = (i >= 10 && i < 20);
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        lo = $urandom_range(0, 60000);
        hi = lo + $urandom_range(0, 1500);
        if (sel == 0) hi = lo - $urandom_range(1, 20);
        send_request(ACT_SEGMENT, lo, hi);
      end else if (sel == 5) begin
        lo = {$urandom(), $urandom()};
        hi = lo + $urandom_range(0, 300);
        if (hi < lo) hi = ALL_ONES;
        send_request(ACT_SEGMENT, lo, hi);
      end else if (sel < 9) begin
        hi = (sel == 8) ? {$urandom(), $urandom()} : 64'($urandom_range(0, 1100000));
        send_request(ACT_TEST, {$urandom(), $urandom()}, hi);
      end else begin
        send_request(ACT_NONE, {$urandom(), $urandom()}, {$urandom(), $urandom()});
      end
    end
    no_idle = 0;
    drain();
  endtask

  task automatic test_backpressure();
    long_hold = 400;
    for (int i = 0; i < 6; i++) send_request(ACT_TEST, 0, 64'($urandom_range(0, 5000)));
    drain();
  endtask

  task automatic test_odd_entries();
    send_request(ACT_LOAD, 4, 0);
    send_request(ACT_LOAD, 1, 0);
    send_request(ACT_LOAD, 0, 0);
    send_request(ACT_LOAD, 64'hABCD_0000_0000_0009, 0);
    send_request(ACT_TEST, 0, 1018081);
    send_request(ACT_SEGMENT, 1000000, 1001000);
    drain();
    send_request(ACT_TEST, 0, 1018081);
    send_request(ACT_TEST, 0, 99991);
    send_request(ACT_SEGMENT, 0, 500);
    drain();
  endtask

  initial begin
    n_seg = 0;
    n_test = 0;
    n_load = 0;
    no_idle = 0;
    long_hold = 0;
    base_len = 0;
    largest_prime = 2;
    rst = 1'b1;
    req_ch.valid  <= 1'b0;
    req_ch.action <= ACT_LOAD;
    req_ch.lower  <= '0;
    req_ch.upper  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_load_primes();
    test_directed();
    test_random();
    test_backpressure();
    test_odd_entries();
    $display("covered %0d segment counts, %0d primality tests, %0d table loads",
             n_seg, n_test, n_load);
    $display("with random idling on both channels, a long response stall and odd table entries");
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
